// ----- hdl/heap_ordered_fifo_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Heap ordered FIFO queue assertion macros
// Short forms for the concurrent checks used in the queue RTL.
// ----------------------------------------------------------------------------
`ifndef HEAP_ORDERED_FIFO_QUEUE_ASSERT_SVH
`define HEAP_ORDERED_FIFO_QUEUE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define HOFQ_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HOFQ_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HOFQ_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hofq_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap ordered FIFO queue package
// Shared types, status codes and sequencer states for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hofq_pkg;

  localparam int ValueW = 32;
  localparam int StampW = 32;
  localparam int CapW   = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_MOV,
    S_DN_L,
    S_DN_R,
    S_DN_RC,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/heap_ordered_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// Heap ordered FIFO queue
// First-in first-out queue kept as a binary min-heap on arrival stamps.
// ----------------------------------------------------------------------------
// Each enqueued value is stored in a heap RAM together with a 32-bit arrival
// stamp. The stamp comes from a counter that advances on every accepted
// enqueue. The root always holds the oldest entry. Stamps are ordered by the
// sign of their wrapped difference, so the order survives counter wrap.
// One item is worked on at a time: in_ready is high only while the sequencer
// is idle. Each operation runs through these steps:
//   - Enqueue: an entry that lands at the root is written at once; else each
//     level checked takes a parent read, then a compare and a write. A fresh
//     stamp is always the youngest, so in practice it never climbs.
//   - Dequeue: a root read, then a read of the last entry, which becomes the
//     moved entry. Each level whose children are compared takes a RAM read
//     for the left child, a RAM read for the right child, a child compare,
//     then a compare with the moved entry and a write (no right-child read or
//     child compare when there is only a left child). A further write step
//     follows when the moved entry comes to rest at a slot with no children.
//   - Refused enqueue (status full) or dequeue when empty: straight to result.
// The single RAM read port and the one shared 32-bit stamp subtractor set
// these steps. The result sits in an output register, so the next item is
// taken while it waits for out_ready. If that register still holds an
// untaken result, the item waits in its last step until out_ready frees it.
// Enqueue is refused once the entry count reaches the smaller of the cap
// register (written through cfg_wr_en/cfg_wr_data, reset 16) and DEPTH.
// Heap RAM needs no clearing after reset: only slots below the count are read.
`default_nettype none

`include "heap_ordered_fifo_queue_assert.svh"

module heap_ordered_fifo_queue #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [hofq_pkg::CapW-1:0]   cfg_wr_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic signed [hofq_pkg::ValueW-1:0] value_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [hofq_pkg::ValueW-1:0] value_out,
  output logic [1:0]                  status
);

  import hofq_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = AW + 2;
  localparam int CMPW = (CW > CapW) ? CW : CapW;

  // control state
  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [StampW-1:0] counter, counter_next;
  logic [CapW-1:0] cap;

  // sift working registers
  logic [AW-1:0]   hole, hole_next;
  logic [CW-1:0]   last_idx, last_idx_next;
  entry_t          mov, mov_next;
  entry_t          child, child_next;
  logic [AW-1:0]   child_idx, child_idx_next;
  logic [ValueW-1:0] res_value, res_value_next;
  logic [1:0]      res_status, res_status_next;

  // output register
  logic              out_valid_next;
  logic [ValueW-1:0] value_out_next;
  logic [1:0]        status_next;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  // shared stamp comparator
  logic [StampW-1:0] cmp_a, cmp_b, stamp_diff;
  logic              is_older;

  // index arithmetic
  logic [AW-1:0] hole_m1, parent;
  logic [IW-1:0] left_ext, right_ext, last_ext;
  logic          is_full;

  hofq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // One subtractor serves every stamp compare; a is older than b when a-b < 0.
  assign stamp_diff = cmp_a - cmp_b;
  assign is_older   = stamp_diff[StampW-1];

  assign hole_m1   = hole - AW'(1);
  assign parent    = hole_m1 >> 1;
  assign left_ext  = {1'b0, hole, 1'b1};
  assign right_ext = left_ext + IW'(1);
  assign last_ext  = IW'(last_idx);

  // Full when the count meets either the written limit or the storage depth.
  assign is_full = (CMPW'(count) >= CMPW'(cap)) || (count == CW'(DEPTH));

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      counter   <= '0;
      cap       <= CapReset;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      counter   <= counter_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
    end
    hole       <= hole_next;
    last_idx   <= last_idx_next;
    mov        <= mov_next;
    child      <= child_next;
    child_idx  <= child_idx_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    value_out  <= value_out_next;
    status     <= status_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    counter_next    = counter;
    hole_next       = hole;
    last_idx_next   = last_idx;
    mov_next        = mov;
    child_next      = child;
    child_idx_next  = child_idx;
    res_value_next  = res_value;
    res_status_next = res_status;
    out_valid_next  = out_valid && !out_ready;
    value_out_next  = value_out;
    status_next     = status;
    ram_we          = 1'b0;
    ram_waddr       = hole;
    ram_wdata       = mov;
    ram_raddr       = '0;
    cmp_a           = mov.stamp;
    cmp_b           = ram_rdata.stamp;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_value_next  = '0;
          res_status_next = ST_OK;
          if (op == OP_ENQ) begin
            if (is_full) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              // Take the next stamp; the new entry starts at the end of the heap.
              mov_next.value = value_in;
              mov_next.stamp = counter;
              hole_next      = count[AW-1:0];
              count_next     = count + CW'(1);
              counter_next   = counter + StampW'(1);
              state_next     = S_UP;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              last_idx_next = count - CW'(1);
              count_next    = count - CW'(1);
              state_next    = S_DN_ROOT;
            end
          end
        end
      end

      // Sift up: parent moves down into the hole while the new entry is older.
      S_UP: begin
        if (hole == '0) begin
          ram_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          ram_raddr  = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_a = mov.stamp;
        cmp_b = ram_rdata.stamp;
        ram_we = 1'b1;
        if (is_older) begin
          ram_wdata  = ram_rdata;
          hole_next  = parent;
          state_next = S_UP;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DN_ROOT: begin
        ram_raddr  = '0;
        state_next = S_DN_LAST;
      end

      S_DN_LAST: begin
        res_value_next = ram_rdata.value;
        ram_raddr      = last_idx[AW-1:0];
        state_next     = S_DN_MOV;
      end

      S_DN_MOV: begin
        mov_next   = ram_rdata;
        hole_next  = '0;
        state_next = S_DN_L;
      end

      // Sift down: read the children that exist, pick the older, compare with the mover.
      S_DN_L: begin
        if (left_ext < last_ext) begin
          ram_raddr  = left_ext[AW-1:0];
          state_next = S_DN_R;
        end else begin
          ram_we     = 1'b1;
          state_next = S_DONE;
        end
      end

      S_DN_R: begin
        child_next     = ram_rdata;
        child_idx_next = left_ext[AW-1:0];
        if (right_ext < last_ext) begin
          ram_raddr  = right_ext[AW-1:0];
          state_next = S_DN_RC;
        end else begin
          state_next = S_DN_CMP;
        end
      end

      S_DN_RC: begin
        cmp_a = ram_rdata.stamp;
        cmp_b = child.stamp;
        if (is_older) begin
          child_next     = ram_rdata;
          child_idx_next = right_ext[AW-1:0];
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_a  = child.stamp;
        cmp_b  = mov.stamp;
        ram_we = 1'b1;
        if (is_older) begin
          ram_wdata  = child;
          hole_next  = child_idx;
          state_next = S_DN_L;
        end else begin
          state_next = S_DONE;
        end
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          value_out_next = res_value;
          status_next    = res_status;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `HOFQ_CHECK(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `HOFQ_NEXT(a_stamp_advance,
             in_valid && in_ready && op == OP_ENQ && !is_full,
             counter == $past(counter) + StampW'(1),
             "stamp counter did not advance on enqueue")
  `HOFQ_IMPLIES(a_empty_zero,
                out_valid && status == ST_EMPTY,
                value_out == '0,
                "empty result carries nonzero value")
  `HOFQ_IMPLIES(a_child_range,
                state == S_DN_CMP,
                IW'(child_idx) < last_ext,
                "sift-down child beyond heap end")

endmodule

`default_nettype wire

// ----- hdl/hofq_ram.sv -----
// ----------------------------------------------------------------------------
// Heap ordered FIFO queue RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module hofq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
